FILE: rtl/dnsarp_pkg.sv
// ----------------------------------------------------------------------------
// DNS A record parser package
// Shared types and constants for the byte-serial DNS reply parser.
// ----------------------------------------------------------------------------
package dnsarp_pkg;

    localparam int unsigned HeaderBytes = 12;
    localparam int unsigned FixedBytes  = 10;
    localparam int unsigned AddrBytes   = 4;

    localparam logic [15:0] QrBit     = 16'h8000;
    localparam logic [15:0] RcodeMask = 16'h000F;
    localparam logic [7:0]  PtrMask   = 8'hC0;

    localparam logic [15:0] TypeA     = 16'd1;
    localparam logic [15:0] LenA      = 16'd4;

    localparam logic [15:0] QTailBytes   = 16'd4;
    localparam logic [15:0] QPtrTailBytes = 16'd5;

    typedef enum logic [2:0] {
        ST_FOUND   = 3'd0,
        ST_SHORT   = 3'd1,
        ST_NOTRESP = 3'd2,
        ST_RCODE   = 3'd3,
        ST_NOANS   = 3'd4,
        ST_NOA     = 3'd5
    } status_t;

    typedef enum logic [8:0] {
        PH_HEADER = 9'b000000001,
        PH_QNAME  = 9'b000000010,
        PH_QSKIP  = 9'b000000100,
        PH_ANAME  = 9'b000001000,
        PH_APTR   = 9'b000010000,
        PH_AFIXED = 9'b000100000,
        PH_ADDR   = 9'b001000000,
        PH_ADATA  = 9'b010000000,
        PH_DONE   = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [31:0] address;
    } result_t;

endpackage

FILE: rtl/dnsarp_if.sv
// ----------------------------------------------------------------------------
// DNS A record parser channels
// Valid/ready channels for the byte input and the result output.
// ----------------------------------------------------------------------------
interface dnsarp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_datagram;

    modport source (output valid, output rx_byte, output end_of_datagram, input ready);
    modport sink   (input valid, input rx_byte, input end_of_datagram, output ready);
endinterface

interface dnsarp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] address;

    modport source (output valid, output status, output address, input ready);
    modport sink   (input valid, input status, input address, output ready);
endinterface

FILE: rtl/dnsarp_in_stage.sv
// ----------------------------------------------------------------------------
// DNS A record parser input stage
// Registers one incoming beat and releases it when the parser takes it.
// ----------------------------------------------------------------------------
module dnsarp_in_stage
    import dnsarp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    dnsarp_byte_if.sink         req,
    input  logic                take,
    output beat_t               beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;

    assign req.ready  = !valid_reg || take;
    assign load       = req.valid && req.ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= req.rx_byte;
            last_reg <= req.end_of_datagram;
        end
    end

    assign beat.valid   = valid_reg;
    assign beat.rx_byte = byte_reg;
    assign beat.last    = last_reg;

endmodule

FILE: rtl/dnsarp_core.sv
// ----------------------------------------------------------------------------
// DNS A record parser core
// Holds the parse state and advances it by one byte per taken beat.
// ----------------------------------------------------------------------------
module dnsarp_core
    import dnsarp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  beat_t   beat,
    input  logic    out_free,
    output logic    take,
    output result_t result
);

    phase_t      phase_reg,   phase_next;
    logic [3:0]  offset_reg,  offset_next;
    logic [15:0] skip_reg,    skip_next;
    logic [15:0] flags_reg,   flags_next;
    logic [15:0] answers_reg, answers_next;
    logic [3:0]  field_reg,   field_next;
    logic [15:0] rtype_reg,   rtype_next;
    logic [15:0] dlen_reg,    dlen_next;
    logic [31:0] addr_reg,    addr_next;
    status_t     verdict_reg, verdict_next;

    logic [7:0]  b;
    logic [15:0] answers_dec;
    logic        is_ptr;
    status_t     final_status;

    assign b      = beat.rx_byte;
    assign is_ptr = (b & PtrMask) == PtrMask;
    assign take   = beat.valid && (!beat.last || out_free);
    assign answers_dec = answers_reg - 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        skip_next    = skip_reg;
        flags_next   = flags_reg;
        answers_next = answers_reg;
        field_next   = field_reg;
        rtype_next   = rtype_reg;
        dlen_next    = dlen_reg;
        addr_next    = addr_reg;
        verdict_next = verdict_reg;

        unique case (phase_reg)
            PH_HEADER:
            begin
                case (offset_reg)
                    4'd2:    flags_next   = {b, flags_reg[7:0]};
                    4'd3:    flags_next   = {flags_reg[15:8], b};
                    4'd6:    answers_next = {b, answers_reg[7:0]};
                    4'd7:    answers_next = {answers_reg[15:8], b};
                    default: ;
                endcase
                offset_next = offset_reg + 4'd1;
                if (offset_reg == 4'(HeaderBytes - 1))
                begin
                    if ((flags_next & QrBit) == 16'd0)
                    begin
                        verdict_next = ST_NOTRESP;
                        phase_next   = PH_DONE;
                    end
                    else if ((flags_next & RcodeMask) != 16'd0)
                    begin
                        verdict_next = ST_RCODE;
                        phase_next   = PH_DONE;
                    end
                    else if (answers_next == 16'd0)
                    begin
                        verdict_next = ST_NOANS;
                        phase_next   = PH_DONE;
                    end
                    else
                    begin
                        verdict_next = ST_NOA;
                        phase_next   = PH_QNAME;
                        skip_next    = 16'd0;
                    end
                end
            end
            PH_QNAME:
            begin
                if (skip_reg != 16'd0)
                begin
                    skip_next = skip_reg - 16'd1;
                end
                else if (b == 8'd0)
                begin
                    skip_next  = QTailBytes;
                    phase_next = PH_QSKIP;
                end
                else if (is_ptr)
                begin
                    skip_next  = QPtrTailBytes;
                    phase_next = PH_QSKIP;
                end
                else
                begin
                    skip_next = {8'd0, b};
                end
            end
            PH_QSKIP:
            begin
                skip_next = skip_reg - 16'd1;
                if (skip_next == 16'd0)
                begin
                    phase_next = PH_ANAME;
                end
            end
            PH_ANAME:
            begin
                if (skip_reg != 16'd0)
                begin
                    skip_next = skip_reg - 16'd1;
                end
                else if (b == 8'd0)
                begin
                    phase_next = PH_AFIXED;
                    field_next = 4'd0;
                end
                else if (is_ptr)
                begin
                    phase_next = PH_APTR;
                end
                else
                begin
                    skip_next = {8'd0, b};
                end
            end
            PH_APTR:
            begin
                phase_next = PH_AFIXED;
                field_next = 4'd0;
            end
            PH_AFIXED:
            begin
                case (field_reg)
                    4'd0:    rtype_next = {b, 8'd0};
                    4'd1:    rtype_next = rtype_reg | {8'd0, b};
                    4'd8:    dlen_next  = {b, 8'd0};
                    4'd9:    dlen_next  = dlen_reg | {8'd0, b};
                    default: ;
                endcase
                if (field_reg >= 4'(FixedBytes - 1))
                begin
                    field_next = 4'd0;
                    if (rtype_next == TypeA && dlen_next == LenA)
                    begin
                        phase_next = PH_ADDR;
                        addr_next  = 32'd0;
                    end
                    else if (dlen_next == 16'd0)
                    begin
                        answers_next = answers_dec;
                        phase_next   = (answers_dec == 16'd0) ? PH_DONE : PH_ANAME;
                        skip_next    = 16'd0;
                    end
                    else
                    begin
                        skip_next  = dlen_next;
                        phase_next = PH_ADATA;
                    end
                end
                else
                begin
                    field_next = field_reg + 4'd1;
                end
            end
            PH_ADDR:
            begin
                addr_next  = {addr_reg[23:0], b};
                field_next = field_reg + 4'd1;
                if (field_next >= 4'(AddrBytes))
                begin
                    verdict_next = ST_FOUND;
                    phase_next   = PH_DONE;
                end
            end
            PH_ADATA:
            begin
                skip_next = skip_reg - 16'd1;
                if (skip_next == 16'd0)
                begin
                    answers_next = answers_dec;
                    phase_next   = (answers_dec == 16'd0) ? PH_DONE : PH_ANAME;
                    skip_next    = 16'd0;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign final_status = (phase_next == PH_HEADER) ? ST_SHORT : verdict_next;

    always_comb
    begin
        result.valid   = take && beat.last;
        result.status  = final_status;
        result.address = (final_status == ST_FOUND) ? addr_next : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            offset_reg  <= 4'd0;
            skip_reg    <= 16'd0;
            flags_reg   <= 16'd0;
            answers_reg <= 16'd0;
            field_reg   <= 4'd0;
            rtype_reg   <= 16'd0;
            dlen_reg    <= 16'd0;
            addr_reg    <= 32'd0;
            verdict_reg <= ST_NOA;
        end
        else if (take)
        begin
            if (beat.last)
            begin
                phase_reg   <= PH_HEADER;
                offset_reg  <= 4'd0;
                skip_reg    <= 16'd0;
                flags_reg   <= 16'd0;
                answers_reg <= 16'd0;
                field_reg   <= 4'd0;
                rtype_reg   <= 16'd0;
                dlen_reg    <= 16'd0;
                addr_reg    <= 32'd0;
                verdict_reg <= ST_NOA;
            end
            else
            begin
                phase_reg   <= phase_next;
                offset_reg  <= offset_next;
                skip_reg    <= skip_next;
                flags_reg   <= flags_next;
                answers_reg <= answers_next;
                field_reg   <= field_next;
                rtype_reg   <= rtype_next;
                dlen_reg    <= dlen_next;
                addr_reg    <= addr_next;
                verdict_reg <= verdict_next;
            end
        end
    end

    // A result leaves only together with the final beat of a datagram.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (beat.valid && beat.last))
        else $error("result without final beat");

    // The address is nonzero only for a found record.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_FOUND) |-> (result.address == 32'd0))
        else $error("address set without a found record");

    // After the final beat the parser is back in the header phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && beat.last) |=> (phase_reg == PH_HEADER && offset_reg == 4'd0))
        else $error("parser did not re-arm after final beat");

    // The header phase only lasts for the header bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (offset_reg < 4'(HeaderBytes)))
        else $error("header offset out of range");

endmodule

FILE: rtl/dnsarp_out_stage.sv
// ----------------------------------------------------------------------------
// DNS A record parser output stage
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module dnsarp_out_stage
    import dnsarp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  result_t           result,
    output logic              out_free,
    dnsarp_result_if.source   rsp
);

    logic        valid_reg;
    logic        valid_next;
    status_t     status_reg;
    logic [31:0] address_reg;

    assign out_free   = !valid_reg || rsp.ready;
    assign valid_next = result.valid ? 1'b1 : (rsp.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            status_reg  <= result.status;
            address_reg <= result.address;
        end
    end

    assign rsp.valid   = valid_reg;
    assign rsp.status  = status_reg;
    assign rsp.address = address_reg;

endmodule

FILE: rtl/dns_a_record_response_parser.sv
// ----------------------------------------------------------------------------
// DNS A record response parser
// Parses a DNS reply byte by byte and reports the first IPv4 A record.
// ----------------------------------------------------------------------------
// The parser accepts one reply byte per clock cycle and never stalls on its
// own; the only back-pressure comes from a held result that the downstream
// side has not yet taken, which blocks the final byte of the next datagram.
// Each byte passes through an input register and the combinational parse
// logic; the status and address of a datagram are held in the result
// register after the core takes the final beat from the input register.
module dns_a_record_response_parser
    import dnsarp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    dnsarp_byte_if.sink      req,
    dnsarp_result_if.source  rsp
);

    beat_t   beat;
    result_t result;
    logic    take;
    logic    out_free;

    dnsarp_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .beat  (beat)
    );

    dnsarp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat     (beat),
        .out_free (out_free),
        .take     (take),
        .result   (result)
    );

    dnsarp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .out_free (out_free),
        .rsp      (rsp)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DNS A record response parser testbench
// Feeds directed and random DNS replies one byte per beat, predicts the status
// and address of each datagram, and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb;
    import dnsarp_pkg::*;

    localparam int StallLimit = 2000;
    localparam int QuietFrom  = 300;
    localparam int QuietTo    = 900;

    typedef struct {
        logic [7:0] rx_byte;
        logic       last;
    } pending_beat_t;

    typedef struct {
        status_t     status;
        logic [31:0] address;
    } reply_outcome_t;

    logic clk;
    logic rst_n;

    dnsarp_byte_if   req_if ();
    dnsarp_result_if rsp_if ();

    dns_a_record_response_parser u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    pending_beat_t  beat_q[$];
    reply_outcome_t outcome_q[$];
    logic [7:0]     dgram[$];
    int unsigned    byte_total;
    int unsigned    dgram_count;
    int unsigned    error_count;
    int unsigned    cycle_count;
    int unsigned    stall_cycles;
    logic           byte_taken;
    logic           quiet;

    logic [15:0] hdr_count;
    phase_t      ph;
    logic [15:0] skip_cnt;
    logic [15:0] hdr_flags;
    logic [15:0] ans_left;
    logic [3:0]  fld;
    logic [15:0] rr_type;
    logic [15:0] rr_len;
    logic [31:0] addr_acc;
    status_t     verdict;

    assign quiet = (cycle_count >= QuietFrom) && (cycle_count < QuietTo);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic clear_parser();
        hdr_count = '0;
        ph        = PH_HEADER;
        skip_cnt  = '0;
        hdr_flags = '0;
        ans_left  = '0;
        fld       = '0;
        rr_type   = '0;
        rr_len    = '0;
        addr_acc  = '0;
        verdict   = ST_NOA;
    endtask

    task automatic finish_record();
        ans_left = ans_left - 16'd1;
        ph       = (ans_left == 16'd0) ? PH_DONE : PH_ANAME;
        skip_cnt = '0;
    endtask

    task automatic parse_reply_byte(input logic [7:0] b, input logic last);
        reply_outcome_t o;
        if (ph == PH_HEADER)
        begin
            case (hdr_count)
                16'd2: hdr_flags[15:8] = b;
                16'd3: hdr_flags[7:0] = b;
                16'd6: ans_left[15:8] = b;
                16'd7: ans_left[7:0] = b;
                default: ;
            endcase
            hdr_count = hdr_count + 16'd1;
            if (hdr_count == HeaderBytes)
            begin
                if ((hdr_flags & QrBit) == 16'd0)
                begin
                    verdict = ST_NOTRESP;
                    ph      = PH_DONE;
                end
                else if ((hdr_flags & RcodeMask) != 16'd0)
                begin
                    verdict = ST_RCODE;
                    ph      = PH_DONE;
                end
                else if (ans_left == 16'd0)
                begin
                    verdict = ST_NOANS;
                    ph      = PH_DONE;
                end
                else
                begin
                    verdict  = ST_NOA;
                    ph       = PH_QNAME;
                    skip_cnt = '0;
                end
            end
        end
        else
        begin
            case (ph)
                PH_QNAME:
                begin
                    if (skip_cnt != 16'd0)
                        skip_cnt = skip_cnt - 16'd1;
                    else if (b == 8'd0)
                    begin
                        skip_cnt = QTailBytes;
                        ph       = PH_QSKIP;
                    end
                    else if ((b & PtrMask) == PtrMask)
                    begin
                        skip_cnt = QPtrTailBytes;
                        ph       = PH_QSKIP;
                    end
                    else
                        skip_cnt = {8'd0, b};
                end
                PH_QSKIP:
                begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0)
                        ph = PH_ANAME;
                end
                PH_ANAME:
                begin
                    if (skip_cnt != 16'd0)
                        skip_cnt = skip_cnt - 16'd1;
                    else if (b == 8'd0)
                    begin
                        ph  = PH_AFIXED;
                        fld = '0;
                    end
                    else if ((b & PtrMask) == PtrMask)
                        ph = PH_APTR;
                    else
                        skip_cnt = {8'd0, b};
                end
                PH_APTR:
                begin
                    ph  = PH_AFIXED;
                    fld = '0;
                end
                PH_AFIXED:
                begin
                    if (fld == 4'd0)
                        rr_type = {b, 8'h00};
                    else if (fld == 4'd1)
                        rr_type = rr_type | {8'h00, b};
                    else if (fld == 4'd8)
                        rr_len = {b, 8'h00};
                    else if (fld == 4'd9)
                        rr_len = rr_len | {8'h00, b};
                    if (fld >= 4'd9)
                    begin
                        fld = '0;
                        if (rr_type == TypeA && rr_len == LenA)
                        begin
                            ph       = PH_ADDR;
                            addr_acc = '0;
                        end
                        else if (rr_len == 16'd0)
                            finish_record();
                        else
                        begin
                            skip_cnt = rr_len;
                            ph       = PH_ADATA;
                        end
                    end
                    else
                        fld = fld + 4'd1;
                end
                PH_ADDR:
                begin
                    addr_acc = {addr_acc[23:0], b};
                    fld      = fld + 4'd1;
                    if (fld >= AddrBytes)
                    begin
                        verdict = ST_FOUND;
                        ph      = PH_DONE;
                    end
                end
                PH_ADATA:
                begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0)
                        finish_record();
                end
                default: ;
            endcase
        end
        if (last)
        begin
            o.status  = (ph == PH_HEADER) ? ST_SHORT : verdict;
            o.address = (o.status == ST_FOUND) ? addr_acc : 32'd0;
            outcome_q.push_back(o);
            clear_parser();
        end
    endtask

    task automatic put_u16(input logic [15:0] v);
        dgram.push_back(v[15:8]);
        dgram.push_back(v[7:0]);
    endtask

    task automatic put_random(input int n);
        repeat (n) dgram.push_back(8'($urandom));
    endtask

    task automatic put_header(input logic [15:0] flags, input logic [15:0] ancount);
        put_u16(16'($urandom));
        put_u16(flags);
        put_u16(16'($urandom));
        put_u16(ancount);
        put_u16(16'($urandom));
        put_u16(16'($urandom));
    endtask

    task automatic put_name();
        int n_labels;
        int len;
        n_labels = $urandom_range(0, 3);
        for (int i = 0; i < n_labels; i++)
        begin
            if ($urandom_range(99) < 3)
                len = $urandom_range(8'h40, 8'hBF);
            else
                len = $urandom_range(1, 8);
            dgram.push_back(8'(len));
            put_random(len);
        end
        if ($urandom_range(1) == 1)
        begin
            dgram.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            put_random(1);
        end
        else
            dgram.push_back(8'h00);
    endtask

    task automatic put_question();
        put_name();
        put_random(4);
    endtask

    task automatic put_record(input logic [15:0] rtype, input logic [15:0] rlen,
                              input int fill);
        put_name();
        put_u16(rtype);
        put_u16(16'($urandom));
        put_random(4);
        put_u16(rlen);
        if (fill < 0)
            put_random(rlen);
        else
            repeat (rlen) dgram.push_back(8'(fill));
    endtask

    task automatic send_dgram();
        for (int i = 0; i < dgram.size(); i++)
            beat_q.push_back('{rx_byte: dgram[i], last: (i == dgram.size() - 1)});
        byte_total  += dgram.size();
        dgram_count += 1;
        dgram.delete();
    endtask

    task automatic build_reply();
        int          n_ans;
        int          a_pos;
        int          cut;
        logic [15:0] flags;
        logic [15:0] ancount;
        logic [15:0] rtype;
        logic [15:0] rlen;
        n_ans = $urandom_range(1, 4);
        a_pos = $urandom_range(0, n_ans);
        flags = (16'($urandom) | QrBit) & ~RcodeMask;
        if ($urandom_range(9) == 0)
            ancount = 16'($urandom_range(1, 16'hFFFF));
        else
            ancount = 16'(n_ans);
        put_header(flags, ancount);
        put_question();
        for (int i = 0; i < n_ans; i++)
        begin
            if (i == a_pos)
                put_record(TypeA, LenA, -1);
            else
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        rtype = TypeA;
                        rlen  = 16'($urandom_range(0, 8));
                        if (rlen == LenA)
                            rlen = 16'd5;
                    end
                    1:
                    begin
                        rtype = 16'($urandom);
                        if (rtype == TypeA)
                            rtype = 16'd28;
                        rlen = LenA;
                    end
                    default:
                    begin
                        rtype = 16'($urandom);
                        if (rtype == TypeA)
                            rtype = 16'h0100;
                        rlen = 16'($urandom_range(0, 12));
                    end
                endcase
                put_record(rtype, rlen, -1);
            end
        end
        put_random($urandom_range(0, 3));
        if ($urandom_range(4) == 0)
        begin
            cut = $urandom_range(1, dgram.size());
            while (dgram.size() > cut)
                void'(dgram.pop_back());
        end
    endtask

    task automatic build_rejected();
        logic [15:0] flags;
        logic [15:0] ancount;
        ancount = 16'($urandom);
        case ($urandom_range(2))
            0: flags = 16'($urandom) & ~QrBit;
            1:
            begin
                flags = 16'($urandom) | QrBit;
                if ((flags & RcodeMask) == 16'd0)
                    flags = flags | 16'($urandom_range(1, 15));
            end
            default:
            begin
                flags   = (16'($urandom) | QrBit) & ~RcodeMask;
                ancount = 16'd0;
            end
        endcase
        put_header(flags, ancount);
        put_random($urandom_range(0, 20));
    endtask

    initial
    begin
        int pick;
        rst_n                  = 1'b0;
        req_if.valid           = 1'b0;
        req_if.rx_byte         = 8'h00;
        req_if.end_of_datagram = 1'b0;
        rsp_if.ready           = 1'b0;
        byte_taken             = 1'b0;
        byte_total             = 0;
        dgram_count            = 0;
        error_count            = 0;
        cycle_count            = 0;
        stall_cycles           = 0;
        clear_parser();

        dgram.push_back(8'hFF);
        send_dgram();
        repeat (11) dgram.push_back(8'h00);
        send_dgram();
        put_header(QrBit, 16'd1);
        send_dgram();
        put_header(16'h7FFF, 16'hFFFF);
        dgram.push_back(8'hFF);
        send_dgram();
        put_header(16'h800F, 16'h0000);
        send_dgram();
        put_header(16'hFFF0, 16'h0000);
        dgram.push_back(8'h00);
        send_dgram();
        put_header(16'h8180, 16'd1);
        put_question();
        put_record(TypeA, LenA, 8'hFF);
        put_random(3);
        send_dgram();
        put_header(16'h8180, 16'd3);
        put_question();
        put_record(16'd5, 16'd0, -1);
        put_record(TypeA, 16'd5, -1);
        put_record(TypeA, LenA, 8'h00);
        send_dgram();
        put_header(16'h8180, 16'd1);
        put_question();
        put_record(TypeA, LenA, -1);
        void'(dgram.pop_back());
        void'(dgram.pop_back());
        send_dgram();
        put_header(16'h8180, 16'd1);
        put_question();
        put_record(16'd28, 16'd16, -1);
        put_record(TypeA, LenA, -1);
        send_dgram();
        put_header(16'h8180, 16'd1);
        dgram.push_back(8'h40);
        put_random(64);
        dgram.push_back(8'hBF);
        put_random(191);
        dgram.push_back(8'h00);
        put_random(4);
        put_record(TypeA, LenA, -1);
        send_dgram();

        while (byte_total < 1450 || dgram_count < 45)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                build_reply();
            else if (pick < 80)
                build_rejected();
            else if (pick < 90)
                put_random($urandom_range(1, 40));
            else
                put_random($urandom_range(1, 11));
            send_dgram();
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (beat_q.size() != 0 || req_if.valid)
            @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    always @(negedge clk)
    begin : drive_beats
        pending_beat_t nb;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (!req_if.valid || byte_taken)
            begin
                if (beat_q.size() != 0 && (quiet || $urandom_range(99) >= 11))
                begin
                    nb                      = beat_q.pop_front();
                    req_if.valid           <= 1'b1;
                    req_if.rx_byte         <= nb.rx_byte;
                    req_if.end_of_datagram <= nb.last;
                end
                else
                    req_if.valid <= 1'b0;
            end
            rsp_if.ready <= quiet || ($urandom_range(99) >= 11);
        end
    end

    always @(posedge clk)
    begin : watch_results
        reply_outcome_t want;
        if (rst_n)
        begin
            byte_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready)
                parse_reply_byte(req_if.rx_byte, req_if.end_of_datagram);
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t unexpected result: status %0d, address %h",
                             $realtime, rsp_if.status, rsp_if.address);
                    error_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (rsp_if.status !== want.status)
                    begin
                        $display("%0t status mismatch: expected %0d, actual %0d",
                                 $realtime, want.status, rsp_if.status);
                        error_count++;
                    end
                    if (rsp_if.address !== want.address)
                    begin
                        $display("%0t address mismatch: expected %h, actual %h",
                                 $realtime, want.address, rsp_if.address);
                        error_count++;
                    end
                end
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= StallLimit)
            begin
                $display("%0t watchdog: no beat accepted for %0d cycles",
                         $realtime, StallLimit);
                $display("tb: done, errors");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
